FILE: hw/rtl/dpf_pkg.sv
// dpf_pkg: shared types for the distinct prime factor unit
// controller state encoding and divider status bundle; no dependencies
package dpf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_FOUND,
    ST_END,
    ST_ONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: hw/rtl/dpf_divider.sv
// dpf_divider: bit-serial restoring divider, one quotient bit per cycle
// uses dpf_pkg::div_sts_t for its status bundle
module dpf_divider #(
  parameter int N_BITS = 32,
  parameter int D_W    = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [N_BITS-1:0] dividend,
  input  logic [D_W-1:0]    divisor,
  output dpf_pkg::div_sts_t sts,
  output logic [N_BITS-1:0] quotient,
  output logic [D_W-1:0]    remainder
);

  localparam int CNT_W = (N_BITS > 1) ? $clog2(N_BITS) : 1;

  logic [N_BITS-1:0] dq_r, dq_nxt;
  logic [D_W-1:0]    pr_r, pr_nxt;
  logic [D_W-1:0]    dv_r, dv_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [D_W:0]      trial;
  logic [D_W:0]      diff;
  logic              fits;

  // shift in the next dividend bit and try the subtraction
  assign trial = {pr_r, dq_r[N_BITS-1]};
  assign diff  = trial - {1'b0, dv_r};
  assign fits  = trial >= {1'b0, dv_r};

  always_comb begin
    dq_nxt   = dq_r;
    pr_nxt   = pr_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = dividend;
      pr_nxt   = '0;
      dv_nxt   = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[N_BITS-2:0], fits};
      pr_nxt  = fits ? diff[D_W-1:0] : trial[D_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(N_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    pr_r  <= pr_nxt;
    dv_r  <= dv_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = dq_r;
  assign remainder = pr_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r)))
    else $error("done without a finished division");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");
`endif

endmodule

FILE: hw/rtl/distinct_prime_factors_trial_division_unit.sv
// distinct_prime_factors_trial_division_unit: top level, trial-division sequencer
// depends on dpf_pkg and dpf_divider
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | in_number
//  out     | output    | out_valid/out_ready | out_factor, out_has_factor, out_last
//
// each trial divisor is handled in order: ST_START launches the bit-serial divider,
// ST_DIV waits through its quotient steps and decides once the divider reports done.
// an item's time grows with the number of divisors tried, up to sqrt of the largest
// remainder over 2. synchronous reset clears the sequencer and the output valid. a
// stalled output holds the sequencer whenever a factor is found or the item ends;
// a new input is taken once the last result is registered.
module distinct_prime_factors_trial_division_unit #(
  parameter int N_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [N_BITS-1:0] in_number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [N_BITS-1:0] out_factor,
  output logic              out_has_factor,
  output logic              out_last
);

  // divisors never pass sqrt(2^N_BITS)+2
  localparam int D_W = (N_BITS + 1) / 2 + 1;

  dpf_pkg::state_t   state_r, state_nxt;
  logic [N_BITS-1:0] rem_r, rem_nxt;
  logic [D_W-1:0]    d_r, d_nxt;
  logic [D_W-1:0]    pend_r, pend_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              dividing_r, dividing_nxt;

  logic              out_valid_r;
  logic [N_BITS-1:0] out_factor_r;
  logic              out_has_r;
  logic              out_last_r;

  logic              emit;
  logic [N_BITS-1:0] emit_factor;
  logic              emit_has;
  logic              emit_last;
  logic              slot_free;

  logic              div_start;
  dpf_pkg::div_sts_t div_sts;
  logic [N_BITS-1:0] div_q;
  logic [D_W-1:0]    div_r;

  logic              d_gt_q;
  logic              r_zero;
  logic              rem_gt1;
  logic [D_W-1:0]    d_inc;

  dpf_divider #(
    .N_BITS (N_BITS),
    .D_W    (D_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rem_r),
    .divisor   (d_r),
    .sts       (div_sts),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign d_gt_q    = N_BITS'(d_r) > div_q;
  assign r_zero    = div_r == '0;
  assign rem_gt1   = rem_r > N_BITS'(1);
  assign d_inc     = (d_r == D_W'(2)) ? D_W'(3) : d_r + D_W'(2);
  assign in_ready  = state_r == dpf_pkg::ST_IDLE;
  assign div_start = state_r == dpf_pkg::ST_START;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_number <= N_BITS'(1)) ? dpf_pkg::ST_ONE : dpf_pkg::ST_START;
        end
      end
      dpf_pkg::ST_START: state_nxt = dpf_pkg::ST_DIV;
      dpf_pkg::ST_DIV: begin
        if (div_sts.done) begin
          if (dividing_r)  state_nxt = dpf_pkg::ST_START;
          else if (d_gt_q) state_nxt = dpf_pkg::ST_END;
          else if (r_zero) state_nxt = dpf_pkg::ST_FOUND;
          else             state_nxt = dpf_pkg::ST_START;
        end
      end
      dpf_pkg::ST_FOUND: begin
        if (slot_free) state_nxt = dpf_pkg::ST_START;
      end
      dpf_pkg::ST_END: begin
        if (slot_free && !(rem_gt1 && pend_valid_r)) state_nxt = dpf_pkg::ST_IDLE;
      end
      dpf_pkg::ST_ONE: begin
        if (slot_free) state_nxt = dpf_pkg::ST_IDLE;
      end
      default: state_nxt = dpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rem_nxt        = rem_r;
    d_nxt          = d_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    dividing_nxt   = dividing_r;
    emit           = 1'b0;
    emit_factor    = '0;
    emit_has       = 1'b0;
    emit_last      = 1'b0;
    unique case (state_r)
      dpf_pkg::ST_IDLE: begin
        if (in_valid) begin
          rem_nxt        = in_number;
          d_nxt          = D_W'(2);
          pend_valid_nxt = 1'b0;
          dividing_nxt   = 1'b0;
        end
      end
      dpf_pkg::ST_START: begin
      end
      dpf_pkg::ST_DIV: begin
        if (div_sts.done) begin
          if (dividing_r) begin
            if (r_zero) begin
              rem_nxt = div_q;
            end else begin
              dividing_nxt = 1'b0;
              d_nxt        = d_inc;
            end
          end else if (!d_gt_q && !r_zero) begin
            d_nxt = d_inc;
          end
        end
      end
      dpf_pkg::ST_FOUND: begin
        // a new factor pushes out the one held back, which is then not last
        if (slot_free) begin
          emit           = pend_valid_r;
          emit_factor    = N_BITS'(pend_r);
          emit_has       = 1'b1;
          pend_nxt       = d_r;
          pend_valid_nxt = 1'b1;
          rem_nxt        = div_q;
          dividing_nxt   = 1'b1;
        end
      end
      dpf_pkg::ST_END: begin
        if (slot_free) begin
          emit     = 1'b1;
          emit_has = 1'b1;
          if (rem_gt1) begin
            if (pend_valid_r) begin
              emit_factor    = N_BITS'(pend_r);
              pend_valid_nxt = 1'b0;
            end else begin
              emit_factor = rem_r;
              emit_last   = 1'b1;
            end
          end else begin
            emit_factor = N_BITS'(pend_r);
            emit_last   = 1'b1;
          end
        end
      end
      dpf_pkg::ST_ONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    pend_r <= pend_nxt;
    if (emit) begin
      out_factor_r <= emit_factor;
      out_has_r    <= emit_has;
      out_last_r   <= emit_last;
    end
    if (!rst_n) begin
      state_r      <= dpf_pkg::ST_IDLE;
      pend_valid_r <= 1'b0;
      dividing_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      dividing_r   <= dividing_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_factor     = out_factor_r;
  assign out_has_factor = out_has_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("result written over an untaken transaction");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");
  a_first_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (d_r == D_W'(2)))
    else $error("trial division does not start at two");
  a_pend_prime: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_r >= D_W'(2)))
    else $error("held factor below two");
`endif

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for distinct_prime_factors_trial_division_unit
// predicts the distinct prime factors of every accepted number by trial division and
// checks the result stream in order; needs the unit's rtl, dpf_divider and dpf_pkg
module tb;

  localparam int N_BITS       = 32;
  localparam int TRIAL_BUDGET = 300;          // keeps random numbers cheap to factor
  localparam int UNBOUNDED    = 32'h7fff_ffff;
  localparam int HOLD_CYCLES  = 2000;
  localparam int TAIL_CYCLES  = 8 * (N_BITS + 2);

  typedef struct packed {
    logic [N_BITS-1:0] factor;
    logic              has_factor;
    logic              last;
  } prime_result_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [N_BITS-1:0] in_number      = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [N_BITS-1:0] out_factor;
  logic              out_has_factor;
  logic              out_last;

  logic [N_BITS-1:0] pending_numbers[$];
  prime_result_t     factor_scratch[$];
  prime_result_t     factors_due[$];
  prime_result_t     due_now;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  logic              hold_req       = 1'b0;
  int                hold_left      = 0;
  int                fail_count     = 0;

  int unsigned small_primes[15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
  int          idle_plan[4]     = '{0, 88, 0, 19};
  int          stall_plan[4]    = '{0, 0, 88, 19};

  // one, small primes, repeated factors, prime squares, a lone large prime,
  // nine distinct factors, top bit alone and all ones
  logic [N_BITS-1:0] corner_numbers[17] = '{
    32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd12, 32'd49, 32'd4725, 32'd30030,
    32'd912673, 32'd999983, 32'd4000012, 32'd16752649, 32'd223092870,
    32'h8000_0000, 32'hffff_ffff
  };

  always #1 clk = ~clk;

  distinct_prime_factors_trial_division_unit #(
    .N_BITS(N_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_factor    (out_factor),
    .out_has_factor(out_has_factor),
    .out_last      (out_last)
  );

  // fills factor_scratch with the factors of n; returns the divisor steps spent,
  // or -1 once more than cap steps would be needed
  function automatic int factorize(logic [N_BITS-1:0] n, int cap);
    logic [63:0]   rem;
    logic [63:0]   d;
    int            cost;
    prime_result_t r;
    rem  = n;
    d    = 2;
    cost = 0;
    factor_scratch.delete();
    r.has_factor = 1'b1;
    r.last       = 1'b0;
    if (rem <= 1) begin
      r.factor     = '0;
      r.has_factor = 1'b0;
      r.last       = 1'b1;
      factor_scratch.push_back(r);
      return 0;
    end
    while (d <= rem / d) begin
      cost++;
      if (rem % d == 0) begin
        r.factor = d[N_BITS-1:0];
        factor_scratch.push_back(r);
        while (rem % d == 0) begin
          rem = rem / d;
          cost++;
        end
      end
      if (cost > cap) return -1;
      d = (d == 2) ? 3 : d + 2;
    end
    if (rem > 1) begin
      r.factor = rem[N_BITS-1:0];
      factor_scratch.push_back(r);
    end
    r      = factor_scratch.pop_back();
    r.last = 1'b1;
    factor_scratch.push_back(r);
    return cost;
  endfunction

  // random number whose factoring stays within the trial budget
  function automatic logic [N_BITS-1:0] pick_number();
    logic [63:0] acc;
    int unsigned q;
    for (int t = 0; t < 64; t++) begin
      acc = 1;
      repeat ($urandom_range(1, 10)) begin
        q = small_primes[$urandom_range(0, 14)];
        if (acc * q <= 64'hffff_ffff) acc = acc * q;
      end
      case ($urandom_range(0, 4))
        0: ;
        1: begin
          // grow to the top bit with twos and threes
          while (acc <= 64'h7fff_ffff)
            acc = acc * ((acc * 3 <= 64'hffff_ffff && $urandom_range(0, 1) == 1) ? 3 : 2);
        end
        2: acc = $urandom;
        3: acc = $urandom_range(1, 20000);
        default: begin
          if (acc * 200000 <= 64'hffff_ffff) acc = acc * $urandom_range(2, 200000);
        end
      endcase
      if (acc != 0 && factorize(acc[N_BITS-1:0], TRIAL_BUDGET) >= 0) return acc[N_BITS-1:0];
    end
    return 30030;
  endfunction

  // driver: offers pending numbers, predicts each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        void'(factorize(in_number, UNBOUNDED));
        foreach (factor_scratch[i]) factors_due.push_back(factor_scratch[i]);
      end
      if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        in_number <= pending_numbers.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (factors_due.size() == 0) begin
          $error("unexpected result: factor %0d has_factor %0d last %0d",
                 out_factor, out_has_factor, out_last);
          fail_count++;
        end else begin
          due_now = factors_due.pop_front();
          if (out_factor !== due_now.factor) begin
            $error("factor: expected %0d, got %0d", due_now.factor, out_factor);
            fail_count++;
          end
          if (out_has_factor !== due_now.has_factor) begin
            $error("has_factor: expected %0d, got %0d", due_now.has_factor, out_has_factor);
            fail_count++;
          end
          if (out_last !== due_now.last) begin
            $error("last: expected %0d, got %0d", due_now.last, out_last);
            fail_count++;
          end
        end
      end
      out_ready <= !hold_req && hold_left == 0 && $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  task automatic set_pace(int idle, int stall);
    @(negedge clk);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
  endtask

  // sender pause: nothing left to send and every predicted result received
  task automatic settle();
    @(negedge clk);
    while (pending_numbers.size() != 0 || in_valid || factors_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_pace(0, 0);
    foreach (corner_numbers[i]) pending_numbers.push_back(corner_numbers[i]);
    settle();

    for (int p = 0; p < 4; p++) begin
      set_pace(idle_plan[p], stall_plan[p]);
      repeat (18) pending_numbers.push_back(pick_number());
      settle();
    end

    // receiver holds off while cheap numbers keep coming, so the unit backs up
    set_pace(0, 0);
    hold_req = 1'b1;
    repeat (10) pending_numbers.push_back($urandom_range(2, 5000));
    @(negedge clk);
    hold_req = 1'b0;
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && factors_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
